>>> design/icsp_pkg.sv
// Shared types and constants of the programming-sequence planner.
// No dependencies; icsp_front, icsp_queue, icsp_back and the top level import this package.
`default_nettype none

package icsp_pkg;

  typedef enum logic [2:0] {
    OP_FLAT_READ   = 3'd0,
    OP_CFG_READ    = 3'd1,
    OP_ERASE_SETUP = 3'd2,
    OP_POWER_OFF   = 3'd3,
    OP_FORMAT      = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ACT_RESTART   = 3'd0,
    ACT_LOAD_CFG  = 3'd1,
    ACT_RUN       = 3'd2,
    ACT_READ_PROG = 3'd3,
    ACT_READ_DATA = 3'd4,
    ACT_POWER_OFF = 3'd5,
    ACT_WORD      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_PROG = 2'd1,
    MODE_CONF = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_CONFIG_START = 2'd0,
    CFG_CONFIG_END   = 2'd1,
    CFG_DATA_START   = 2'd2,
    CFG_DATA_END     = 2'd3
  } cfg_index_t;

  localparam logic [15:0] CONFIG_START_RESET = 16'h2000;
  localparam logic [15:0] CONFIG_END_RESET   = 16'h2007;
  localparam logic [15:0] DATA_START_RESET   = 16'h2100;
  localparam logic [15:0] DATA_END_RESET     = 16'h217F;
  localparam logic [13:0] ERASE_WORD         = 14'h3FFF;
  localparam logic [13:0] DATA_WORD_MASK     = 14'h00FF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Planned operations of one request, emitted in field order.
  typedef struct packed {
    logic        restart;
    logic        load_cfg;
    logic        erase;
    logic        run;
    logic [15:0] run_count;
    logic        fin;
    action_t     fin_action;
    logic [13:0] fin_payload;
  } plan_t;

endpackage

`default_nettype wire

>>> design/icsp_req_if.sv
// Request channel: opcode, address and raw response with valid/ready.
// No dependencies.
`default_nettype none

interface icsp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] address;
  logic [15:0] raw_response;

  modport source (output valid, output opcode, output address, output raw_response,
                  input ready);
  modport sink (input valid, input opcode, input address, input raw_response,
                output ready);
endinterface

`default_nettype wire

>>> design/icsp_res_if.sv
// Result channel: planned action, payload, repeat count and last flag.
// No dependencies.
`default_nettype none

interface icsp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [13:0] payload;
  logic [15:0] repeat_count;
  logic        last;

  modport source (output valid, output action, output payload, output repeat_count,
                  output last, input ready);
  modport sink (input valid, input action, input payload, input repeat_count,
                input last, output ready);
endinterface

`default_nettype wire

>>> design/icsp_front.sv
// Front end: takes requests, decodes regions, tracks target mode and counter,
// and pushes at most one plan per request, none when the plan holds no operation. Depends on icsp_pkg and icsp_req_if.
`default_nettype none

module icsp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  icsp_req_if.sink             req,
  input  wire logic            q_full,
  output logic                 push,
  output icsp_pkg::plan_t      plan
);
  import icsp_pkg::*;

  logic [15:0] config_start, config_end, data_start, data_end;
  mode_t       mode, mode_next;
  logic [15:0] counter, counter_next;
  logic        last_data, last_data_next;

  logic        accept;
  logic        in_data, in_cfg;
  logic [15:0] data_off, cfg_off;
  logic        is_read, rd_cfg;
  logic [15:0] off, base;
  logic        below;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;

  assign in_data  = (req.address >= data_start) && (req.address <= data_end);
  assign in_cfg   = (req.address >= config_start) && (req.address <= config_end);
  assign data_off = req.address - data_start;
  assign cfg_off  = req.address - config_start;

  always_comb begin
    plan           = '0;
    plan.fin_action = ACT_READ_PROG;
    mode_next      = mode;
    counter_next   = counter;
    last_data_next = last_data;
    is_read        = 1'b0;
    rd_cfg         = 1'b0;
    off            = req.address;
    unique case (opcode_t'(req.opcode))
      OP_FLAT_READ: begin
        is_read  = 1'b1;
        plan.fin = 1'b1;
        if (in_data) begin
          off             = data_off;
          plan.fin_action = ACT_READ_DATA;
          last_data_next  = 1'b1;
        end else if (in_cfg) begin
          rd_cfg         = 1'b1;
          off            = cfg_off;
          last_data_next = 1'b0;
        end else begin
          last_data_next = 1'b0;
        end
      end
      OP_CFG_READ: begin
        is_read        = 1'b1;
        rd_cfg         = 1'b1;
        plan.fin       = 1'b1;
        last_data_next = 1'b0;
      end
      OP_ERASE_SETUP: begin
        plan.restart  = 1'b1;
        plan.load_cfg = 1'b1;
        plan.erase    = 1'b1;
        mode_next     = MODE_CONF;
        counter_next  = '0;
      end
      OP_POWER_OFF: begin
        if (mode != MODE_OFF) begin
          plan.fin        = 1'b1;
          plan.fin_action = ACT_POWER_OFF;
          mode_next       = MODE_OFF;
          counter_next    = '0;
        end
      end
      OP_FORMAT: begin
        plan.fin         = 1'b1;
        plan.fin_action  = ACT_WORD;
        plan.fin_payload = last_data ? (req.raw_response[14:1] & DATA_WORD_MASK)
                                     : req.raw_response[14:1];
      end
      default: begin
      end
    endcase

    below = off < counter;
    if (is_read) begin
      if (rd_cfg) begin
        plan.restart  = (mode == MODE_OFF) || ((mode != MODE_PROG) && below);
        plan.load_cfg = plan.restart || (mode == MODE_PROG);
        mode_next     = MODE_CONF;
      end else begin
        plan.restart = (mode != MODE_PROG) || below;
        mode_next    = MODE_PROG;
      end
      base           = (plan.restart || plan.load_cfg) ? 16'd0 : counter;
      plan.run       = off != base;
      plan.run_count = off - base;
      counter_next   = off;
    end else begin
      base = counter;
    end
  end

  assign push = accept && (plan.restart || plan.load_cfg || plan.run || plan.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_OFF;
      counter      <= '0;
      last_data    <= 1'b0;
      config_start <= CONFIG_START_RESET;
      config_end   <= CONFIG_END_RESET;
      data_start   <= DATA_START_RESET;
      data_end     <= DATA_END_RESET;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        counter   <= counter_next;
        last_data <= last_data_next;
      end
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_CONFIG_START: config_start <= cfg_data;
          CFG_CONFIG_END:   config_end   <= cfg_data;
          CFG_DATA_START:   data_start   <= cfg_data;
          CFG_DATA_END:     data_end     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> design/icsp_queue.sv
// Short plan queue between front and back ends.
// Depends on icsp_pkg.
`default_nettype none

module icsp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire icsp_pkg::plan_t  push_data,
  output logic                  full,
  input  wire logic             pop,
  output icsp_pkg::plan_t       pop_data,
  output logic                  empty
);
  import icsp_pkg::*;

  plan_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    do_push, do_pop;

  assign full     = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/icsp_back.sv
// Back end: pops plans and emits their operations one per cycle while res.ready is high.
// Depends on icsp_pkg and icsp_res_if.
`default_nettype none

module icsp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire icsp_pkg::plan_t q_data,
  output logic                 pop,
  icsp_res_if.source           res
);
  import icsp_pkg::*;

  plan_t   cur, rest;
  logic    cur_valid;
  action_t act;
  logic    is_last, advance;

  always_comb begin
    rest              = cur;
    res.payload       = '0;
    res.repeat_count  = '0;
    if (cur.restart) begin
      act          = ACT_RESTART;
      rest.restart = 1'b0;
    end else if (cur.load_cfg) begin
      act           = ACT_LOAD_CFG;
      res.payload   = cur.erase ? ERASE_WORD : 14'd0;
      rest.load_cfg = 1'b0;
    end else if (cur.run) begin
      act              = ACT_RUN;
      res.repeat_count = cur.run_count;
      rest.run         = 1'b0;
    end else begin
      act         = cur.fin_action;
      res.payload = cur.fin_payload;
      rest.fin    = 1'b0;
    end
  end

  assign is_last    = !(rest.restart || rest.load_cfg || rest.run || rest.fin);
  assign res.valid  = cur_valid;
  assign res.action = act;
  assign res.last   = is_last;
  assign advance    = !cur_valid || (res.ready && is_last);
  assign pop        = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (advance) begin
      cur_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!q_empty) begin
        cur <= q_data;
      end
    end else if (res.ready) begin
      cur <= rest;
    end
  end

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.action == ACT_RUN) |-> res.repeat_count != 16'd0)
    else $error("increment run with zero count");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.action != ACT_LOAD_CFG) && (res.action != ACT_WORD)
    |-> res.payload == 14'd0)
    else $error("payload on an action that carries none");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && !res.last |=> res.valid)
    else $error("request results broken off before last");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> !cur_valid || (res.ready && res.last))
    else $error("plan popped while results still pending");

endmodule

`default_nettype wire

>>> design/icsp_address_sequencer_unit.sv
// Top level of the in-circuit programming sequence planner.
// Depends on icsp_pkg, icsp_req_if, icsp_res_if, icsp_front, icsp_queue, icsp_back.
//
// A request is taken whenever the two-entry plan queue has room; the front
// end updates target mode, address counter and data-read flag at once, so
// requests may arrive every cycle while the queue is not full. The back end
// emits one result per cycle while the result channel is ready; a request
// yields zero to four results (one for power off and response formatting, up
// to four for a read that needs restart, load config and an increment run).
// The single result port of the back end sets the sustained rate. Configuration
// writes take effect on the next cycle and need no idle time beyond the usual rule.
`default_nettype none

module icsp_address_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  icsp_req_if.sink         req,
  icsp_res_if.source       res
);
  import icsp_pkg::*;

  plan_t push_plan, pop_plan;
  logic  push, pop, q_full, q_empty;

  icsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .plan      (push_plan)
  );

  icsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_plan),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_plan),
    .empty     (q_empty)
  );

  icsp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (pop_plan),
    .pop     (pop),
    .res     (res)
  );

endmodule

`default_nettype wire

>>> bench/tb_icsp_address_sequencer_unit.sv
// Testbench of icsp_address_sequencer_unit: predicts the planned operations of each request
// and checks every result in order. Depends on icsp_pkg, icsp_req_if, icsp_res_if and the
// design files under test.
`timescale 1ns / 100ps

module tb_icsp_address_sequencer_unit;
  import icsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [13:0] WORD_MASK = 14'h3FFF;

  typedef struct packed {
    action_t     action;
    logic [13:0] payload;
    logic [15:0] count;
    logic        last;
  } planned_op_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  icsp_req_if req_ch ();
  icsp_res_if res_ch ();

  icsp_address_sequencer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  planned_op_t pending_ops[$];
  planned_op_t plan_ops[$];

  mode_t       target_mode;
  logic [15:0] address_counter;
  logic        read_was_data;
  logic [15:0] cfg_start;
  logic [15:0] cfg_end;
  logic [15:0] data_start;
  logic [15:0] data_end;

  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Planner state mirror

  function automatic void add_op(action_t act, logic [13:0] pay, logic [15:0] cnt);
    planned_op_t op;
    op.action = act;
    op.payload = pay;
    op.count = cnt;
    op.last = 1'b0;
    plan_ops.push_back(op);
  endfunction

  function automatic void restart_target();
    target_mode = MODE_PROG;
    address_counter = '0;
    add_op(ACT_RESTART, '0, '0);
  endfunction

  function automatic void advance_to(logic [15:0] target);
    if (address_counter < target) begin
      add_op(ACT_RUN, '0, target - address_counter);
      address_counter = target;
    end
  endfunction

  function automatic void seek_config(logic [15:0] off);
    if (target_mode == MODE_OFF) begin
      restart_target();
      add_op(ACT_LOAD_CFG, '0, '0);
      target_mode = MODE_CONF;
    end else if (target_mode == MODE_PROG) begin
      add_op(ACT_LOAD_CFG, '0, '0);
      target_mode = MODE_CONF;
      address_counter = '0;
    end else if (off < address_counter) begin
      restart_target();
      add_op(ACT_LOAD_CFG, '0, '0);
      target_mode = MODE_CONF;
    end
    advance_to(off);
  endfunction

  function automatic void seek_program(logic [15:0] off);
    if (target_mode != MODE_PROG || off < address_counter)
      restart_target();
    advance_to(off);
  endfunction

  function automatic void plan_request(logic [2:0] opc, logic [15:0] addr, logic [15:0] raw);
    planned_op_t op;
    plan_ops.delete();
    case (opc)
      OP_FLAT_READ: begin
        if (addr >= data_start && addr <= data_end) begin
          seek_program(addr - data_start);
          add_op(ACT_READ_DATA, '0, '0);
          read_was_data = 1'b1;
        end else if (addr >= cfg_start && addr <= cfg_end) begin
          seek_config(addr - cfg_start);
          add_op(ACT_READ_PROG, '0, '0);
          read_was_data = 1'b0;
        end else begin
          seek_program(addr);
          add_op(ACT_READ_PROG, '0, '0);
          read_was_data = 1'b0;
        end
      end
      OP_CFG_READ: begin
        seek_config(addr);
        add_op(ACT_READ_PROG, '0, '0);
        read_was_data = 1'b0;
      end
      OP_ERASE_SETUP: begin
        restart_target();
        add_op(ACT_LOAD_CFG, ERASE_WORD, '0);
        target_mode = MODE_CONF;
      end
      OP_POWER_OFF: begin
        if (target_mode != MODE_OFF) begin
          target_mode = MODE_OFF;
          address_counter = '0;
          add_op(ACT_POWER_OFF, '0, '0);
        end
      end
      OP_FORMAT: begin
        add_op(ACT_WORD, raw[14:1] & (read_was_data ? DATA_WORD_MASK : WORD_MASK), '0);
      end
      default: ;
    endcase
    if (plan_ops.size() > 0) begin
      op = plan_ops[plan_ops.size() - 1];
      op.last = 1'b1;
      plan_ops[plan_ops.size() - 1] = op;
    end
    foreach (plan_ops[i]) pending_ops.push_back(plan_ops[i]);
  endfunction

  // Result side: random stall, compare each accepted result with the oldest plan

  always @(posedge clk) begin
    planned_op_t exp_op;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_ops.size() == 0) begin
        $display("%0t: unexpected result, action %0d payload %0h count %0h last %0b", $time,
                 res_ch.action, res_ch.payload, res_ch.repeat_count, res_ch.last);
        errors++;
      end else begin
        exp_op = pending_ops.pop_front();
        if (res_ch.action !== exp_op.action) begin
          $display("%0t: action mismatch, expected %0d, actual %0d", $time,
                   exp_op.action, res_ch.action);
          errors++;
        end
        if (res_ch.payload !== exp_op.payload) begin
          $display("%0t: payload mismatch, expected %0h, actual %0h", $time,
                   exp_op.payload, res_ch.payload);
          errors++;
        end
        if (res_ch.repeat_count !== exp_op.count) begin
          $display("%0t: repeat_count mismatch, expected %0h, actual %0h", $time,
                   exp_op.count, res_ch.repeat_count);
          errors++;
        end
        if (res_ch.last !== exp_op.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b", $time,
                   exp_op.last, res_ch.last);
          errors++;
        end
      end
    end
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Request side

  task automatic send_request(input logic [2:0] opc, input logic [15:0] addr,
                              input logic [15:0] raw);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= opc;
    req_ch.address <= addr;
    req_ch.raw_response <= raw;
    do @(posedge clk); while (!req_ch.ready);
    plan_request(opc, addr, raw);
  endtask

  // Hold requests until every planned result has come out, then let the block settle.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regions(input logic [15:0] cs, input logic [15:0] ce,
                             input logic [15:0] ds, input logic [15:0] de);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CONFIG_START;
    cfg_data <= cs;
    @(posedge clk);
    cfg_index <= CFG_CONFIG_END;
    cfg_data <= ce;
    @(posedge clk);
    cfg_index <= CFG_DATA_START;
    cfg_data <= ds;
    @(posedge clk);
    cfg_index <= CFG_DATA_END;
    cfg_data <= de;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_start = cs;
    cfg_end = ce;
    data_start = ds;
    data_end = de;
  endtask

  function automatic logic [15:0] pick_in(logic [15:0] lo, logic [15:0] hi);
    if (lo > hi) return 16'($urandom);
    return lo + 16'($urandom_range(hi - lo));
  endfunction

  function automatic logic [15:0] pick_address();
    case ($urandom_range(3))
      0: return pick_in(data_start, data_end);
      1: return pick_in(cfg_start, cfg_end);
      2: return 16'($urandom_range(63));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_sequence(output int n);
    int kind;
    logic [15:0] a;
    logic [2:0] opc;
    kind = $urandom_range(99);
    if (kind < 45) begin
      send_request(OP_FLAT_READ, pick_address(), 16'($urandom));
      send_request(OP_FORMAT, 16'($urandom), 16'($urandom));
      n = 2;
    end else if (kind < 60) begin
      a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      send_request(OP_CFG_READ, a, 16'($urandom));
      send_request(OP_FORMAT, 16'($urandom), 16'($urandom));
      n = 2;
    end else if (kind < 72) begin
      a = pick_address();
      send_request(OP_FLAT_READ, a, 16'($urandom));
      a = a + 16'($urandom_range(4));
      send_request(OP_FLAT_READ, a, 16'($urandom));
      a = a + 16'($urandom_range(4));
      send_request(OP_FLAT_READ, a, 16'($urandom));
      send_request(OP_FORMAT, 16'($urandom), 16'($urandom));
      n = 4;
    end else if (kind < 80) begin
      send_request(OP_ERASE_SETUP, 16'($urandom), 16'($urandom));
      n = 1;
    end else if (kind < 86) begin
      send_request(OP_POWER_OFF, 16'($urandom), 16'($urandom));
      n = 1;
    end else if (kind < 94) begin
      send_request(OP_FORMAT, 16'($urandom), 16'($urandom));
      n = 1;
    end else begin
      opc = 3'($urandom);
      send_request(opc, 16'($urandom), 16'($urandom));
      n = (opc <= OP_FORMAT) ? 1 : 0;
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input int n_items);
    int sent;
    int n;
    sent = 0;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    while (sent < n_items) begin
      send_random_sequence(n);
      sent += n;
    end
    drain_results();
  endtask

  // Tests

  task automatic test_read_planning();
    send_request(OP_FLAT_READ, 16'h0000, 16'h0000);
    send_request(OP_FLAT_READ, 16'h0000, 16'h0000);
    send_request(OP_FLAT_READ, 16'h0005, 16'h0000);
    send_request(OP_FLAT_READ, 16'h0003, 16'h0000);
    send_request(OP_FORMAT, 16'h0000, 16'hFFFF);
    send_request(OP_CFG_READ, 16'h0002, 16'h0000);
    send_request(OP_FLAT_READ, 16'h2001, 16'h0000);
    send_request(OP_FLAT_READ, 16'h2007, 16'h0000);
    send_request(OP_FLAT_READ, 16'h2100, 16'h0000);
    send_request(OP_FORMAT, 16'hFFFF, 16'hFFFF);
    send_request(OP_FLAT_READ, 16'h217F, 16'h0000);
    send_request(OP_FORMAT, 16'h0000, 16'hAAAA);
    send_request(OP_FLAT_READ, 16'h20FF, 16'h0000);
    send_request(OP_FORMAT, 16'h0000, 16'h5555);
    send_request(OP_FLAT_READ, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_mode_changes();
    send_request(OP_POWER_OFF, 16'h0000, 16'h0000);
    send_request(OP_POWER_OFF, 16'hFFFF, 16'h0000);
    send_request(OP_CFG_READ, 16'h0000, 16'h0000);
    drain_results();
    send_request(OP_ERASE_SETUP, 16'h1234, 16'h0000);
    send_request(3'd5, 16'hFFFF, 16'hFFFF);
    send_request(3'd6, 16'h0000, 16'h0000);
    send_request(3'd7, 16'h5A5A, 16'hA5A5);
    send_request(OP_CFG_READ, 16'hFFFF, 16'h0000);
    send_request(OP_FORMAT, 16'h0000, 16'h0000);
    send_request(OP_FLAT_READ, 16'h2000, 16'h0000);
    drain_results();
  endtask

  task automatic test_random_traffic();
    set_regions(16'h0000, 16'h000F, 16'hFFF0, 16'hFFFF);
    run_phase(0, 0, 50);
    set_regions(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
    run_phase(80, 0, 40);
    set_regions(16'h1000, 16'h10FF, 16'h1080, 16'h117F);
    run_phase(0, 80, 40);
    set_regions(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(31, 31, 50);
    set_regions(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    run_phase(0, 0, 20);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_CONFIG_START;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_FLAT_READ;
    req_ch.address = '0;
    req_ch.raw_response = '0;
    res_ch.ready = 1'b0;
    target_mode = MODE_OFF;
    address_counter = '0;
    read_was_data = 1'b0;
    cfg_start = CONFIG_START_RESET;
    cfg_end = CONFIG_END_RESET;
    data_start = DATA_START_RESET;
    data_end = DATA_END_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_read_planning();
    test_mode_changes();
    test_random_traffic();

    stall_pct = 0;
    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
design/icsp_pkg.sv
design/icsp_req_if.sv
design/icsp_res_if.sv
design/icsp_front.sv
design/icsp_queue.sv
design/icsp_back.sv
design/icsp_address_sequencer_unit.sv
bench/tb_icsp_address_sequencer_unit.sv
